FILE: src/path_normalizer_unit_assert.svh
// Assertion macros for the path normalizer.
// Included by the modules that check their own logic; expects clk and rst_n in scope.
`ifndef PATH_NORMALIZER_UNIT_ASSERT_SVH
`define PATH_NORMALIZER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define PN_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("path normalizer check failed");
`define PN_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |-> (cons))) \
    else $error("path normalizer check failed");
`define PN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) ((ante) |=> (cons))) \
    else $error("path normalizer check failed");
`else
`define PN_ASSERT(lbl, expr)
`define PN_ASSERT_IMPLY(lbl, ante, cons)
`define PN_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

FILE: src/pn_pkg.sv
// Shared types and constants of the path normalizer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package pn_pkg;

  localparam int CMD_W  = 2;
  localparam int CHAR_W = 8;
  localparam int IDX_W  = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHAR  = 2'd0,
    CMD_END   = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DONE     = 2'd1,
    ST_DEPTH    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 8'h5C;

endpackage

FILE: src/pn_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies; used for the output buffer and the component start stack.
`timescale 1ns / 1ps

module pn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: src/path_normalizer_unit.sv
// Path normalizer: one request per cycle while out_ready is high; the result is
// registered and presented in the cycle after acceptance.
// The state update for a request finishes in its accept cycle; the read data comes
// from the registered read port of the output buffer RAM.
// Reset (synchronous, active low) clears the control state; buffer and stack RAMs
// are not swept, reads at or beyond the current length return zero.
`timescale 1ns / 1ps

module path_normalizer_unit
  import pn_pkg::*;
#(
  parameter int MAX_LEN    = 256,
  parameter int COMP_DEPTH = 50
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [CMD_W-1:0]             in_cmd,
  input  logic [CHAR_W-1:0]            in_ch,
  input  logic [IDX_W-1:0]             in_read_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [CHAR_W-1:0]            out_char,
  output logic [$clog2(MAX_LEN+1)-1:0] out_length
);

  `include "path_normalizer_unit_assert.svh"

  localparam int CW  = $clog2(MAX_LEN + 4);  // count, may run past MAX_LEN briefly
  localparam int LW  = $clog2(MAX_LEN + 1);  // committed length and start offsets
  localparam int BAW = $clog2(MAX_LEN);
  localparam int DW  = $clog2(COMP_DEPTH);

  cmd_t cmd;
  logic accept;

  // Path state.
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [LW-1:0] top_r, top_nxt;
  logic [LW-1:0] comp_start_r, comp_start_nxt;
  logic [1:0]    comp_len_r, comp_len_nxt;
  logic          is_abs_r, is_abs_nxt;
  logic          seen_first_r, seen_first_nxt;
  logic          in_comp_r, in_comp_nxt;
  logic          all_dots_r, all_dots_nxt;
  logic          finished_r, finished_nxt;
  logic          dotslash_r, dotslash_nxt;
  status_t       err_r, err_nxt;

  // Result register.
  logic              out_valid_r;
  status_t           out_status_r;
  logic [LW-1:0]     out_length_r;
  logic              char_en_r;
  logic              fixed_en_r;
  logic [CHAR_W-1:0] fixed_char_r;

  // RAM ports.
  logic              buf_we;
  logic [BAW-1:0]    buf_waddr;
  logic [CHAR_W-1:0] buf_wdata;
  logic [BAW-1:0]    buf_raddr;
  logic [CHAR_W-1:0] buf_rdata;
  logic              stk_we;
  logic [DW-1:0]     stk_waddr;
  logic [LW-1:0]     stk_wdata;
  logic [DW-1:0]     stk_raddr;
  logic [LW-1:0]     stk_rdata;

  logic          is_end, is_sep, was_cand, now_cand, dots1, dots2;
  logic [LW-1:0] cs_plus2;
  logic [CW-1:0] commit_n;
  logic [LW-1:0] length_nxt;
  logic          char_en_nxt;
  logic [DW:0]   depth_ext;

  assign cmd      = cmd_t'(in_cmd);
  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign is_end   = (cmd == CMD_END) || (in_ch == CH_NUL);
  assign is_sep   = !is_end && ((in_ch == CH_SLASH) || (in_ch == CH_BSLASH));
  assign dots1    = all_dots_r && (comp_len_r == 2'd1);
  assign dots2    = all_dots_r && (comp_len_r == 2'd2);
  assign cs_plus2 = comp_start_r + LW'(2);

  always_comb begin
    out_count_nxt  = out_count_r;
    depth_nxt      = depth_r;
    top_nxt        = top_r;
    comp_start_nxt = comp_start_r;
    comp_len_nxt   = comp_len_r;
    is_abs_nxt     = is_abs_r;
    seen_first_nxt = seen_first_r;
    in_comp_nxt    = in_comp_r;
    all_dots_nxt   = all_dots_r;
    finished_nxt   = finished_r;
    dotslash_nxt   = dotslash_r;
    err_nxt        = err_r;
    buf_we         = 1'b0;
    buf_waddr      = out_count_r[BAW-1:0];
    buf_wdata      = in_ch;
    stk_we         = 1'b0;
    stk_waddr      = depth_r;
    stk_wdata      = comp_start_r;
    was_cand       = 1'b0;
    now_cand       = 1'b0;

    case (cmd)
      CMD_CLEAR: begin
        out_count_nxt  = '0;
        depth_nxt      = '0;
        comp_start_nxt = '0;
        comp_len_nxt   = 2'd0;
        is_abs_nxt     = 1'b0;
        seen_first_nxt = 1'b0;
        in_comp_nxt    = 1'b0;
        all_dots_nxt   = 1'b1;
        finished_nxt   = 1'b0;
        dotslash_nxt   = 1'b0;
        err_nxt        = ST_OK;
      end
      CMD_READ: begin
        out_count_nxt = out_count_r;
      end
      default: begin
        if (err_r == ST_OK && !finished_r) begin
          if (is_sep && !seen_first_r) begin
            // Leading separator marks an absolute path.
            seen_first_nxt = 1'b1;
            is_abs_nxt     = 1'b1;
            buf_we         = 1'b1;
            buf_wdata      = CH_SLASH;
            out_count_nxt  = out_count_r + CW'(1);
          end else if ((is_end || is_sep) && in_comp_r) begin
            in_comp_nxt = 1'b0;
            if (dots1) begin
              out_count_nxt = CW'(comp_start_r);
            end else if (dots2) begin
              out_count_nxt = CW'(comp_start_r);
              if (depth_r != '0) begin
                // Pop: the cached top is the start of the removed component.
                depth_nxt     = depth_r - DW'(1);
                out_count_nxt = CW'(top_r);
                top_nxt       = stk_rdata;
              end else if (is_abs_r) begin
                out_count_nxt = CW'(1);
              end else if ((LW+1)'(comp_start_r) + (LW+1)'(3) > (LW+1)'(MAX_LEN)) begin
                err_nxt = ST_OVERFLOW;
              end else begin
                // The two dots are already in the buffer; only the slash is new.
                buf_we        = 1'b1;
                buf_waddr     = cs_plus2[BAW-1:0];
                buf_wdata     = CH_SLASH;
                out_count_nxt = CW'(comp_start_r) + CW'(3);
              end
            end else if (is_sep) begin
              if (out_count_r >= CW'(MAX_LEN)) begin
                err_nxt       = ST_OVERFLOW;
                out_count_nxt = CW'(MAX_LEN);
              end else begin
                buf_we        = 1'b1;
                buf_wdata     = CH_SLASH;
                out_count_nxt = out_count_r + CW'(1);
              end
            end
          end else if (!is_end && !is_sep) begin
            seen_first_nxt = 1'b1;
            if (!in_comp_r) begin
              in_comp_nxt    = 1'b1;
              comp_start_nxt = LW'(out_count_r);
              comp_len_nxt   = 2'd0;
              all_dots_nxt   = 1'b1;
            end
            was_cand = all_dots_nxt && (comp_len_nxt <= 2'd2);
            if (comp_len_nxt != 2'd3) begin
              comp_len_nxt = comp_len_nxt + 2'd1;
            end
            if (in_ch != CH_DOT) begin
              all_dots_nxt = 1'b0;
            end
            if (out_count_r < CW'(MAX_LEN)) begin
              buf_we = 1'b1;
            end
            out_count_nxt = out_count_r + CW'(1);
            now_cand      = all_dots_nxt && (comp_len_nxt <= 2'd2);
            if (was_cand && !now_cand && depth_r >= DW'(COMP_DEPTH - 1)) begin
              err_nxt = ST_DEPTH;
            end else begin
              if (was_cand && !now_cand) begin
                stk_we    = 1'b1;
                stk_wdata = comp_start_nxt;
                depth_nxt = depth_r + DW'(1);
                top_nxt   = comp_start_nxt;
              end
              if (!now_cand && out_count_nxt > CW'(MAX_LEN)) begin
                err_nxt       = ST_OVERFLOW;
                out_count_nxt = CW'(MAX_LEN);
              end
            end
          end

          if (is_end) begin
            // An empty result reads back as "./" through a fixed-character override.
            if (err_nxt == ST_OK && out_count_nxt == '0) begin
              dotslash_nxt  = 1'b1;
              out_count_nxt = CW'(2);
            end
            finished_nxt = 1'b1;
          end
        end
      end
    endcase
  end

  // Keep the entry below the top of the stack prefetched for the next pop.
  assign depth_ext = (DW+1)'(depth_nxt);
  assign stk_raddr = (depth_ext >= (DW+1)'(2)) ? DW'(depth_ext - (DW+1)'(2)) : '0;

  always_comb begin
    commit_n = out_count_nxt;
    if (err_nxt == ST_OK && in_comp_nxt && all_dots_nxt && comp_len_nxt <= 2'd2) begin
      commit_n = CW'(comp_start_nxt);
    end
    if (commit_n > CW'(MAX_LEN)) begin
      commit_n = CW'(MAX_LEN);
    end
  end

  assign length_nxt  = LW'(commit_n);
  assign char_en_nxt = (cmd == CMD_READ) &&
                       ((LW+IDX_W)'(in_read_index) < (LW+IDX_W)'(length_nxt));
  assign buf_raddr   = BAW'(in_read_index);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_count_r  <= '0;
      depth_r      <= '0;
      comp_start_r <= '0;
      comp_len_r   <= 2'd0;
      is_abs_r     <= 1'b0;
      seen_first_r <= 1'b0;
      in_comp_r    <= 1'b0;
      all_dots_r   <= 1'b1;
      finished_r   <= 1'b0;
      dotslash_r   <= 1'b0;
      err_r        <= ST_OK;
      out_valid_r  <= 1'b0;
    end else begin
      if (accept) begin
        out_count_r  <= out_count_nxt;
        depth_r      <= depth_nxt;
        comp_start_r <= comp_start_nxt;
        comp_len_r   <= comp_len_nxt;
        is_abs_r     <= is_abs_nxt;
        seen_first_r <= seen_first_nxt;
        in_comp_r    <= in_comp_nxt;
        all_dots_r   <= all_dots_nxt;
        finished_r   <= finished_nxt;
        dotslash_r   <= dotslash_nxt;
        err_r        <= err_nxt;
        out_valid_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      top_r        <= top_nxt;
      out_status_r <= (err_nxt != ST_OK) ? err_nxt : (finished_nxt ? ST_DONE : ST_OK);
      out_length_r <= length_nxt;
      char_en_r    <= char_en_nxt;
      fixed_en_r   <= char_en_nxt && dotslash_nxt;
      fixed_char_r <= in_read_index[0] ? CH_SLASH : CH_DOT;
    end
  end

  pn_ram #(
    .WIDTH(CHAR_W),
    .DEPTH(MAX_LEN)
  ) u_buf_ram (
    .clk    (clk),
    .wr_en  (accept && buf_we),
    .wr_addr(buf_waddr),
    .wr_data(buf_wdata),
    .rd_en  (accept),
    .rd_addr(buf_raddr),
    .rd_data(buf_rdata)
  );

  pn_ram #(
    .WIDTH(LW),
    .DEPTH(COMP_DEPTH)
  ) u_stack_ram (
    .clk    (clk),
    .wr_en  (accept && stk_we),
    .wr_addr(stk_waddr),
    .wr_data(stk_wdata),
    .rd_en  (accept),
    .rd_addr(stk_raddr),
    .rd_data(stk_rdata)
  );

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_length = out_length_r;
  assign out_char   = fixed_en_r ? fixed_char_r : (char_en_r ? buf_rdata : '0);

  `PN_ASSERT(a_depth_bound, depth_r <= DW'(COMP_DEPTH - 1))
  `PN_ASSERT_IMPLY(a_done_closed, finished_r, !in_comp_r)
  `PN_ASSERT_IMPLY(a_dotslash_len, dotslash_r, finished_r && out_count_r == CW'(2))
  `PN_ASSERT_NEXT(a_err_frozen, err_r != ST_OK && accept && cmd != CMD_CLEAR, $stable(out_count_r))

endmodule
